FILE: hdl/ire_pkg.sv
// package for the ipc rendezvous engine: status codes, modes, special peer numbers,
// sequencer states and the table row type
// no dependencies
`default_nettype none
package ire_pkg;

  localparam int unsigned NumProcsDef = 16;

  localparam logic [4:0] ANY       = 5'd16;
  localparam logic [4:0] INTERRUPT = 5'd17;
  localparam logic [4:0] NO_TASK   = 5'd31;

  typedef enum logic [1:0] {
    MODE_SEND = 2'd0,
    MODE_RECV = 2'd1,
    MODE_IRQ  = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_IRQ       = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_BAD       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHAIN,
    S_ENQ,
    S_UNLINK,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic       sending;
    logic       receiving;
    logic [4:0] target;
    logic [4:0] source;
    logic       irq;
    logic [4:0] head;
    logic [4:0] next;
  } row_t;

endpackage
`default_nettype wire

FILE: hdl/ipc_rendezvous_engine_core.sv
// Blocking send/receive rendezvous for up to NumProcs processes. One request is taken
// when start_i is high and busy_o low; busy_o then stays high until the single result
// is shown for one cycle on done_o, in the last busy cycle. busy_o covers a decode state
// and a result state plus, for a send, the steps of the deadlock chain walk and a step to
// close it, and, when the caller joins a non-empty sender queue, the queue steps and a
// step to close them; a receive from a waiting sender adds the queue steps and a step to
// close them. Each walk stops after NumProcs steps. The walks share one row lookup per
// cycle. The receiver cannot stall: each result must be taken in the cycle that done_o
// is high.
// depends on ire_pkg and ire_ram
`default_nettype none
module ipc_rendezvous_engine_core
  import ire_pkg::*;
#(
  parameter int unsigned NumProcs = NumProcsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  mode_i,
  input  wire  [3:0]  caller_i,
  input  wire  [4:0]  peer_i,
  input  wire  [31:0] msg_addr_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        woken_valid_o,
  output logic [3:0]  woken_o,
  output logic [31:0] copy_to_o,
  output logic [31:0] copy_from_o,
  output logic [4:0]  msg_source_o
);
  localparam int unsigned IdxW = $clog2(NumProcs);
  localparam int unsigned CntW = $clog2(NumProcs + 1);

  row_t rows_q [NumProcs];

  seq_state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [3:0]  caller_q;
  logic [4:0]  peer_q;
  logic [31:0] addr_q;
  logic [4:0]  ptr_q, ptr_d, prev_q, prev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [4:0]  who_q, who_d; // partner chosen for receive

  logic [2:0]  st_d;
  logic        wv_d;
  logic [3:0]  wk_d;
  logic        to_buf_d, from_buf_d; // which copy field comes from the ram
  logic [31:0] to_d, from_d;
  logic [4:0]  src_d;
  logic [2:0]  st_q;
  logic        wv_q;
  logic [3:0]  wk_q;
  logic        to_buf_q, from_buf_q;
  logic [31:0] to_q, from_q;
  logic [4:0]  src_q;

  // buffer address store
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [31:0]     ram_rdata;

  ire_ram #(.Width(32), .Depth(NumProcs)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (addr_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic is_proc(logic [4:0] n);
    return (n < 5'd16) && ({27'd0, n} < NumProcs);
  endfunction

  // shared row lookup, one per cycle
  logic [IdxW-1:0] look_idx;
  row_t look;
  row_t crow;
  row_t prow;
  logic [IdxW-1:0] cidx, pidx;

  assign cidx = IdxW'(caller_q);
  assign pidx = IdxW'(peer_q);
  assign crow = rows_q[cidx];
  assign prow = rows_q[pidx];
  assign look = rows_q[look_idx];

  // row update request
  logic       upd_en;
  logic [IdxW-1:0] upd_idx;
  row_t       upd_row;
  logic       upd2_en;
  logic [IdxW-1:0] upd2_idx;
  row_t       upd2_row;

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q; prev_d = prev_q; cnt_d = cnt_q; who_d = who_q;
    st_d = st_q; wv_d = wv_q; wk_d = wk_q; to_d = to_q; from_d = from_q;
    src_d = src_q; to_buf_d = to_buf_q; from_buf_d = from_buf_q;
    look_idx = IdxW'(ptr_q);
    upd_en = 1'b0; upd_idx = cidx; upd_row = crow;
    upd2_en = 1'b0; upd2_idx = cidx; upd2_row = crow;
    ram_we = 1'b0; ram_waddr = cidx; ram_raddr = cidx;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        st_d = ST_BAD; wv_d = 1'b0; wk_d = 4'd0; to_d = '0; from_d = '0; src_d = '0;
        to_buf_d = 1'b0; from_buf_d = 1'b0;
        state_d = S_DONE;
        if ({28'd0, caller_q} >= NumProcs || mode_q == MODE_BAD) begin
          st_d = ST_BAD;
        end else if (mode_q == MODE_IRQ) begin
          if (crow.receiving && (crow.source == ANY || crow.source == INTERRUPT)) begin
            upd_en = 1'b1; upd_row.receiving = 1'b0; upd_row.source = '0;
            st_d = ST_IRQ; wv_d = 1'b1; wk_d = caller_q; to_buf_d = 1'b1;
            src_d = INTERRUPT; ram_raddr = cidx;
          end else begin
            upd_en = 1'b1; upd_row.irq = 1'b1; st_d = ST_DELIVERED;
          end
        end else if (crow.sending || crow.receiving) begin
          st_d = ST_BAD;
        end else if (mode_q == MODE_SEND) begin
          if (is_proc(peer_q) && peer_q != {1'b0, caller_q}) begin
            ptr_d = peer_q; cnt_d = '0; state_d = S_CHAIN;
          end
        end else if (peer_q == ANY || peer_q == INTERRUPT ||
                     (is_proc(peer_q) && peer_q != {1'b0, caller_q})) begin
          if (crow.irq && (peer_q == ANY || peer_q == INTERRUPT)) begin
            upd_en = 1'b1; upd_row.irq = 1'b0;
            st_d = ST_IRQ; to_d = addr_q; src_d = INTERRUPT;
          end else begin
            who_d = NO_TASK;
            if (peer_q == ANY) begin
              if (is_proc(crow.head)) who_d = crow.head;
            end else if (peer_q != INTERRUPT) begin
              if (prow.sending && prow.target == {1'b0, caller_q}) who_d = peer_q;
            end
            if (who_d != NO_TASK) begin
              ram_raddr = IdxW'(who_d);
              st_d = ST_DELIVERED; wv_d = 1'b1; wk_d = who_d[3:0]; to_d = addr_q;
              from_buf_d = 1'b1; src_d = who_d;
              ptr_d = crow.head; prev_d = NO_TASK; cnt_d = '0; state_d = S_UNLINK;
            end else begin
              upd_en = 1'b1; upd_row.receiving = 1'b1; upd_row.source = peer_q;
              ram_we = 1'b1;
              st_d = ST_BLOCKED;
            end
          end
        end
      end
      S_CHAIN: begin
        // walk the send chain from the target looking for the caller
        if (cnt_q == CntW'(NumProcs) || !is_proc(ptr_q) || !look.sending) begin
          if (prow.receiving &&
              (prow.source == {1'b0, caller_q} || prow.source == ANY)) begin
            upd_en = 1'b1; upd_idx = pidx; upd_row = prow;
            upd_row.receiving = 1'b0; upd_row.source = '0;
            ram_raddr = pidx;
            st_d = ST_DELIVERED; wv_d = 1'b1; wk_d = peer_q[3:0]; to_buf_d = 1'b1;
            from_d = addr_q; src_d = {1'b0, caller_q};
            state_d = S_DONE;
          end else begin
            upd_en = 1'b1; upd_row.sending = 1'b1; upd_row.target = peer_q;
            upd_row.next = NO_TASK; ram_we = 1'b1;
            st_d = ST_BLOCKED;
            if (!is_proc(prow.head)) begin
              upd2_en = 1'b1; upd2_idx = pidx; upd2_row = prow;
              upd2_row.head = {1'b0, caller_q};
              state_d = S_DONE;
            end else begin
              ptr_d = prow.head; cnt_d = '0; state_d = S_ENQ;
            end
          end
        end else if (look.target == {1'b0, caller_q}) begin
          st_d = ST_DEADLOCK; state_d = S_DONE;
        end else begin
          ptr_d = look.target; cnt_d = cnt_q + 1'b1;
        end
      end
      S_ENQ: begin
        if (cnt_q == CntW'(NumProcs) || !is_proc(look.next)) begin
          upd2_en = 1'b1; upd2_idx = IdxW'(ptr_q); upd2_row = look;
          upd2_row.next = {1'b0, caller_q};
          state_d = S_DONE;
        end else begin
          ptr_d = look.next; cnt_d = cnt_q + 1'b1;
        end
      end
      S_UNLINK: begin
        if (cnt_q == CntW'(NumProcs) || !is_proc(ptr_q)) begin
          state_d = S_DONE;
        end else if (ptr_q == who_q) begin
          if (is_proc(prev_q)) begin
            upd2_en = 1'b1; upd2_idx = IdxW'(prev_q); upd2_row = rows_q[IdxW'(prev_q)];
            upd2_row.next = look.next;
          end else begin
            upd_en = 1'b1; upd_row.head = look.next;
          end
          state_d = S_DONE;
        end else begin
          prev_d = ptr_q; ptr_d = look.next; cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // unlink also clears the chosen sender; handled at the end of the walk
  logic clr_sender;
  assign clr_sender = (state_q == S_UNLINK) && (state_d == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NumProcs; i++) begin
        rows_q[i] <= '{sending: 1'b0, receiving: 1'b0, target: '0, source: '0,
                       irq: 1'b0, head: NO_TASK, next: NO_TASK};
      end
    end else begin
      state_q <= state_d;
      if (upd_en) rows_q[upd_idx] <= upd_row;
      if (upd2_en) rows_q[upd2_idx] <= upd2_row;
      if (clr_sender) begin
        rows_q[IdxW'(who_q)].sending <= 1'b0;
        rows_q[IdxW'(who_q)].target  <= '0;
        if (ptr_q == who_q && is_proc(ptr_q) && cnt_q != CntW'(NumProcs))
          rows_q[IdxW'(who_q)].next <= NO_TASK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      mode_q <= mode_i; caller_q <= caller_i; peer_q <= peer_i; addr_q <= msg_addr_i;
    end
    ptr_q <= ptr_d; prev_q <= prev_d; cnt_q <= cnt_d; who_q <= who_d;
    st_q <= st_d; wv_q <= wv_d; wk_q <= wk_d; to_q <= to_d; from_q <= from_d;
    src_q <= src_d; to_buf_q <= to_buf_d; from_buf_q <= from_buf_d;
  end

  // ram data is held since nothing else reads it while the walk runs
  logic [31:0] ram_hold_q;
  logic        ram_take_q;
  logic [31:0] ram_val;
  always_ff @(posedge clk_i) begin
    ram_take_q <= (state_q == S_DECIDE) || (state_q == S_CHAIN);
    if (ram_take_q && (to_buf_q || from_buf_q) && state_q != S_DONE)
      ram_hold_q <= ram_rdata;
    else if (ram_take_q && state_q == S_DONE)
      ram_hold_q <= ram_rdata;
  end

  // read data straight from the ram when the result follows the read at once
  assign ram_val = ram_take_q ? ram_rdata : ram_hold_q;

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = st_q;
  assign woken_valid_o = wv_q;
  assign woken_o       = wk_q;
  assign copy_to_o     = to_buf_q ? ram_val : to_q;
  assign copy_from_o   = from_buf_q ? ram_val : from_q;
  assign msg_source_o  = src_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held longer than one cycle");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside busy");
  a_wake_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && woken_valid_o) |-> (status_o == ST_DELIVERED || status_o == ST_IRQ))
    else $error("wake with wrong status");
endmodule
`default_nettype wire

FILE: hdl/ire_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ire_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: test/tb.sv
// testbench for ipc_rendezvous_engine_core: random and directed send/receive/interrupt requests
// checked against a behavioural rendezvous table held in a small scoreboard class
// depends on ire_pkg and the engine rtl
`timescale 1ns / 100ps

typedef struct packed {
  logic [2:0]  status;
  logic        woken_valid;
  logic [3:0]  woken;
  logic [31:0] copy_to;
  logic [31:0] copy_from;
  logic [4:0]  msg_source;
} reply_t;

class rendezvous_board;
  bit          sending [16];
  bit          receiving [16];
  logic [4:0]  target [16];
  logic [4:0]  source [16];
  logic [31:0] buf_addr [16];
  bit          irq [16];
  logic [4:0]  head [16];
  logic [4:0]  nxt [16];
  reply_t      pending_replies [$];
  int          errors;

  function new();
    for (int i = 0; i < 16; i++) begin
      sending[i] = 0; receiving[i] = 0; target[i] = 0; source[i] = 0;
      buf_addr[i] = 0; irq[i] = 0; head[i] = ire_pkg::NO_TASK; nxt[i] = ire_pkg::NO_TASK;
    end
    errors = 0;
  endfunction

  function bit is_proc(logic [4:0] n);
    return n < 16;
  endfunction

  function void push(logic [2:0] st, bit wv, logic [3:0] w, logic [31:0] t,
                     logic [31:0] f, logic [4:0] s);
    reply_t r;
    r.status = st; r.woken_valid = wv; r.woken = w;
    r.copy_to = t; r.copy_from = f; r.msg_source = s;
    pending_replies.push_back(r);
  endfunction

  function bit chain_hits(logic [4:0] start, logic [4:0] who);
    logic [4:0] p;
    p = start;
    for (int n = 0; n < 16; n++) begin
      if (!is_proc(p) || !sending[p[3:0]]) return 0;
      if (target[p[3:0]] == who) return 1;
      p = target[p[3:0]];
    end
    return 0;
  endfunction

  function void enqueue(logic [3:0] d, logic [3:0] who);
    logic [4:0] p, q;
    p = head[d];
    nxt[who] = ire_pkg::NO_TASK;
    if (!is_proc(p)) begin
      head[d] = {1'b0, who};
      return;
    end
    for (int n = 0; n < 16; n++) begin
      q = nxt[p[3:0]];
      if (!is_proc(q)) break;
      p = q;
    end
    nxt[p[3:0]] = {1'b0, who};
  endfunction

  function void unlink(logic [3:0] owner, logic [3:0] who);
    logic [4:0] p, prev;
    p = head[owner];
    prev = ire_pkg::NO_TASK;
    for (int n = 0; n < 16 && is_proc(p); n++) begin
      if (p[3:0] == who) begin
        if (is_proc(prev)) nxt[prev[3:0]] = nxt[p[3:0]];
        else head[owner] = nxt[p[3:0]];
        nxt[p[3:0]] = ire_pkg::NO_TASK;
        return;
      end
      prev = p;
      p = nxt[p[3:0]];
    end
  endfunction

  function void note_request(logic [1:0] mode, logic [3:0] c, logic [4:0] peer,
                             logic [31:0] addr);
    logic [4:0] d;
    if (mode == ire_pkg::MODE_BAD) begin
      push(ire_pkg::ST_BAD, 0, 0, 0, 0, 0); return;
    end
    if (mode == ire_pkg::MODE_IRQ) begin
      if (receiving[c] && (source[c] == ire_pkg::ANY || source[c] == ire_pkg::INTERRUPT)) begin
        receiving[c] = 0; source[c] = 0;
        push(ire_pkg::ST_IRQ, 1, c, buf_addr[c], 0, ire_pkg::INTERRUPT);
      end else begin
        irq[c] = 1;
        push(ire_pkg::ST_DELIVERED, 0, 0, 0, 0, 0);
      end
      return;
    end
    if (sending[c] || receiving[c]) begin
      push(ire_pkg::ST_BAD, 0, 0, 0, 0, 0); return;
    end
    if (mode == ire_pkg::MODE_SEND) begin
      if (!is_proc(peer) || peer[3:0] == c) begin
        push(ire_pkg::ST_BAD, 0, 0, 0, 0, 0); return;
      end
      if (chain_hits(peer, {1'b0, c})) begin
        push(ire_pkg::ST_DEADLOCK, 0, 0, 0, 0, 0); return;
      end
      if (receiving[peer[3:0]] && (source[peer[3:0]] == {1'b0, c} ||
          source[peer[3:0]] == ire_pkg::ANY)) begin
        receiving[peer[3:0]] = 0; source[peer[3:0]] = 0;
        push(ire_pkg::ST_DELIVERED, 1, peer[3:0], buf_addr[peer[3:0]], addr, {1'b0, c});
        return;
      end
      sending[c] = 1; target[c] = peer; buf_addr[c] = addr;
      enqueue(peer[3:0], c);
      push(ire_pkg::ST_BLOCKED, 0, 0, 0, 0, 0);
      return;
    end
    if (!(peer == ire_pkg::ANY || peer == ire_pkg::INTERRUPT ||
          (is_proc(peer) && peer[3:0] != c))) begin
      push(ire_pkg::ST_BAD, 0, 0, 0, 0, 0); return;
    end
    if (irq[c] && (peer == ire_pkg::ANY || peer == ire_pkg::INTERRUPT)) begin
      irq[c] = 0;
      push(ire_pkg::ST_IRQ, 0, 0, addr, 0, ire_pkg::INTERRUPT); return;
    end
    d = ire_pkg::NO_TASK;
    if (peer == ire_pkg::ANY) begin
      if (is_proc(head[c])) d = head[c];
    end else if (peer != ire_pkg::INTERRUPT) begin
      if (sending[peer[3:0]] && target[peer[3:0]] == {1'b0, c}) d = peer;
    end
    if (is_proc(d)) begin
      unlink(c, d[3:0]);
      sending[d[3:0]] = 0; target[d[3:0]] = 0;
      push(ire_pkg::ST_DELIVERED, 1, d[3:0], addr, buf_addr[d[3:0]], d);
      return;
    end
    receiving[c] = 1; source[c] = peer; buf_addr[c] = addr;
    push(ire_pkg::ST_BLOCKED, 0, 0, 0, 0, 0);
  endfunction

  function void check_reply(reply_t got);
    reply_t exp;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply status %0d", $time, got.status);
      errors++;
      return;
    end
    exp = pending_replies.pop_front();
    if (got !== exp) begin
      $display("%0t: expected st=%0d wv=%0d w=%0d to=%h from=%h src=%0d", $time,
               exp.status, exp.woken_valid, exp.woken, exp.copy_to, exp.copy_from,
               exp.msg_source);
      $display("%0t: actual   st=%0d wv=%0d w=%0d to=%h from=%h src=%0d", $time,
               got.status, got.woken_valid, got.woken, got.copy_to, got.copy_from,
               got.msg_source);
      errors++;
    end
  endfunction
endclass

module tb;
  import ire_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [1:0]  mode_i = 0;
  logic [3:0]  caller_i = 0;
  logic [4:0]  peer_i = 0;
  logic [31:0] msg_addr_i = 0;
  logic        busy_o, done_o, woken_valid_o;
  logic [2:0]  status_o;
  logic [3:0]  woken_o;
  logic [31:0] copy_to_o, copy_from_o;
  logic [4:0]  msg_source_o;
  int          idle_pct;
  longint      cycles = 0;
  rendezvous_board board = new();

  ipc_rendezvous_engine_core dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    reply_t r;
    cycles++;
    if (done_o) begin
      r.status = status_o; r.woken_valid = woken_valid_o; r.woken = woken_o;
      r.copy_to = copy_to_o; r.copy_from = copy_from_o; r.msg_source = msg_source_o;
      board.check_reply(r);
    end
    if (cycles > 400000) begin
      $display("ipc_rendezvous_engine_core: mismatch");
      $finish;
    end
  end

  // one transaction; start held until accepted, dropped while the sender idles
  task automatic issue(logic [1:0] m, logic [3:0] c, logic [4:0] p, logic [31:0] a);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(negedge clk_i);
    end
    start_i <= 1; mode_i <= m; caller_i <= c; peer_i <= p; msg_addr_i <= a;
    do @(posedge clk_i); while (busy_o);
    board.note_request(m, c, p, a);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int k;
    logic [4:0] p;
    k = $urandom_range(99);
    if (k < 40) p = 5'($urandom_range(15));
    else if (k < 70) p = ANY;
    else if (k < 85) p = INTERRUPT;
    else p = 5'($urandom_range(31));
    k = $urandom_range(99);
    issue(k < 42 ? MODE_SEND : k < 84 ? MODE_RECV : k < 96 ? MODE_IRQ : MODE_BAD,
          4'($urandom_range(15)), p, $urandom());
  endtask

  initial begin
    idle_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: chains, deadlock, any/named receive, interrupts, bad requests
    issue(MODE_BAD, 0, 0, 0);
    issue(MODE_SEND, 1, 1, 32'h1);
    issue(MODE_SEND, 1, 18, 32'h1);
    issue(MODE_RECV, 1, 1, 32'h1);
    issue(MODE_RECV, 1, 31, 32'h1);
    issue(MODE_SEND, 1, 2, 32'hFFFF_FFFF);
    issue(MODE_SEND, 1, 3, 32'h5);
    issue(MODE_SEND, 3, 2, 32'h0000_1000);
    issue(MODE_SEND, 2, 1, 32'h2);
    issue(MODE_SEND, 15, 2, 32'hA5A5_5A5A);
    issue(MODE_RECV, 2, 15, 32'h2000);
    issue(MODE_RECV, 2, ANY, 32'h3000);
    issue(MODE_RECV, 0, INTERRUPT, 32'h4000);
    issue(MODE_IRQ, 0, 0, 0);
    issue(MODE_IRQ, 5, 0, 0);
    issue(MODE_RECV, 5, ANY, 32'h5000);
    issue(MODE_IRQ, 6, 0, 0);
    issue(MODE_RECV, 6, INTERRUPT, 32'h6000);
    issue(MODE_RECV, 7, ANY, 32'hFFFF_FFFF);
    issue(MODE_SEND, 8, 7, 32'h8000);
    issue(MODE_RECV, 9, 10, 32'h9000);
    issue(MODE_SEND, 10, 9, 32'hA000);
    issue(MODE_RECV, 7, 3, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 45 : (ph == 3) ? 13 : 0;
      for (int i = 0; i < 385; i++) random_item();
      start_i <= 0;
      // hold off until the table has answered everything
      wait (board.pending_replies.size() == 0);
      @(negedge clk_i);
    end
    wait (board.pending_replies.size() == 0);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending_replies.size() == 0)
      $display("ipc_rendezvous_engine_core: match");
    else
      $display("ipc_rendezvous_engine_core: mismatch");
    $finish;
  end
endmodule

FILE: files.f
hdl/ire_pkg.sv
hdl/ire_ram.sv
hdl/ipc_rendezvous_engine_core.sv
test/tb.sv
